### hdl/bf5_pkg.sv
// ----------------------------------------------------------------------------
// bf5_pkg
// shared constants and types for the 5x5 bilateral filter
// ----------------------------------------------------------------------------
`default_nettype none
package bf5_pkg;
  localparam int DIAM = 5;
  localparam int HALF = 2;
  localparam int LINES = DIAM - 1;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int RANGE_ENTRIES = 256;
  localparam int MAX_HEIGHT = 2048;
  localparam int NUM_W = 41;
  localparam int DEN_W = 21;
  localparam int PIX_W = 8;
  localparam int POS_W = 11;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_SW_D0  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SW_D1  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SW_D2  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SW_D4  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SW_D5  = 3'd6;
  localparam logic [IDX_W-1:0] REG_SW_D8  = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } bf5_tag_t;

  typedef struct packed {
    logic [PIX_W*DIAM*DIAM-1:0] win;
    bf5_tag_t                   tag;
  } bf5_job_t;

  function automatic logic [2:0] dist_class(input int dy, input int dx);
    int d2;
    d2 = dy * dy + dx * dx;
    case (d2)
      0: return 3'd0;
      1: return 3'd1;
      2: return 3'd2;
      4: return 3'd3;
      5: return 3'd4;
      default: return 3'd5;
    endcase
  endfunction
endpackage
`default_nettype wire

### hdl/bilateral_filter_5x5.sv
// ----------------------------------------------------------------------------
// bilateral_filter_5x5
// streaming 5x5 bilateral filter for 8-bit single-channel pixels
// ----------------------------------------------------------------------------
// input channel: valid/stall; kind 0 carries a raster pixel, kind 1 writes one
// entry of the range weight table. output channel: valid/stall, one
// transaction per interior pixel with its row, column and frame_last flag.
// config channel: valid/ready write of register index and data; the user
// writes only while idle, which the block itself does not enforce. the front
// end (line buffers, window) takes a pixel a cycle while its queue has room;
// each interior pixel is queued as a job. the back end weighs the 25 taps
// one at a time (through table read, multiplier and accumulator) and then
// runs a 41-step restoring divider; it takes a new job only when the last
// result has left, which sets the sustained rate.
// a table write is stalled until every accepted pixel has been filtered.
// reset clears counters, window, the table (valid bits) and sets the config
// registers to defaults; line buffer contents stay undefined until written.
// a stalled output holds its transaction; the queue fills and then the input
// channel is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module bilateral_filter_5x5 import bf5_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic         kind,
  input  wire logic [7:0]   pixel_value,
  input  wire logic [7:0]   weight_index,
  input  wire logic [15:0]  weight_value,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        filtered_value,
  output logic [10:0]       out_row,
  output logic [10:0]       out_col,
  output logic              frame_last
);
  localparam int QD = 4;
  logic [11:0] frame_width, frame_height;
  logic [16*6-1:0] spatial;
  logic take_px, job_valid, job_take, q_ne;
  logic px_d, back_idle, busy;
  logic [$clog2(QD+1)-1:0] q_count;
  bf5_job_t job, q_out;

  assign cfg_ready = 1'b1;
  // table writes wait until no pixel is in flight
  assign busy = px_d || job_valid || q_ne || !back_idle;
  // two jobs may be in flight in front of the queue
  assign in_stall = (q_count > 3'(QD - 3)) || (kind && busy);
  assign take_px = in_valid && !in_stall && !kind;

  always_ff @(posedge clk) begin
    if (rst) px_d <= 1'b0;
    else px_d <= take_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 12'd640;
      frame_height <= 12'd480;
      spatial <= {6{16'hFFFF}};
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) frame_width <= cfg_data[11:0];
      else if (cfg_index == REG_HEIGHT) frame_height <= cfg_data[11:0];
      else spatial[16*(cfg_index - REG_SW_D0) +: 16] <= cfg_data;
    end
  end

  bf5_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .take(take_px), .pixel_value, .frame_width, .frame_height,
    .job_valid, .job
  );

  bf5_queue #(.DEPTH(QD)) u_queue (
    .clk, .rst, .push(job_valid), .din(job), .pop(job_take),
    .not_empty(q_ne), .count(q_count), .dout(q_out)
  );

  bf5_back u_back (
    .clk, .rst, .job_valid(q_ne), .job(q_out), .job_take, .idle(back_idle),
    .tbl_we(in_valid && !in_stall && kind), .tbl_idx(weight_index),
    .tbl_val(weight_value), .spatial,
    .out_valid, .out_stall, .filtered_value, .out_row, .out_col, .frame_last
  );
endmodule
`default_nettype wire

### hdl/bf5_front.sv
// ----------------------------------------------------------------------------
// bf5_front
// line buffers, 5x5 window and raster position; issues one job per interior pixel
// ----------------------------------------------------------------------------
`default_nettype none
module bf5_front import bf5_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [PIX_W-1:0]  pixel_value,
  input  wire logic [11:0]       frame_width,
  input  wire logic [11:0]       frame_height,
  output logic                   job_valid,
  output bf5_job_t               job
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1) > 12 ? $clog2(MAX_WIDTH + 1) : 12;

  logic [PIX_W*LINES-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] win [DIAM][DIAM];
  logic [CW-1:0] col_count;
  logic [11:0] row_count;
  logic [CW-1:0] w_lim;
  logic [11:0] h_lim;
  logic [CW-1:0] c;
  logic [11:0] r;
  logic [CW-1:0] c_next;
  logic [11:0] r_next;
  logic [PIX_W*LINES-1:0] rd;
  logic pend;
  logic [PIX_W-1:0] pend_px;
  logic [CW-1:0] pend_c;
  logic [11:0] pend_r;
  logic [POS_W-1:0] tag_row;
  logic [POS_W-1:0] tag_col;
  logic tag_last;

  always_comb begin
    if ({{(CW-12){1'b0}}, frame_width} < CW'(DIAM)) w_lim = CW'(DIAM);
    else if ({{(CW-12){1'b0}}, frame_width} > CW'(MAX_WIDTH)) w_lim = CW'(MAX_WIDTH);
    else w_lim = CW'(frame_width);
    if (frame_height < 12'(DIAM)) h_lim = 12'(DIAM);
    else if (frame_height > 12'(MAX_HEIGHT)) h_lim = 12'(MAX_HEIGHT);
    else h_lim = frame_height;
    c = col_count;
    r = row_count;
    if (c >= w_lim) begin
      c = '0;
      r = r + 12'd1;
    end
    if (r >= h_lim) r = '0;
    c_next = c + CW'(1);
    r_next = r;
    if (c_next >= w_lim) begin
      c_next = '0;
      r_next = r + 12'd1;
      if (r_next >= h_lim) r_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rd <= line_mem[c[AW-1:0]];
    if (pend) line_mem[pend_c[AW-1:0]] <= {pend_px, rd[PIX_W*LINES-1:PIX_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      pend <= 1'b0;
      job_valid <= 1'b0;
      for (int i = 0; i < DIAM; i++)
        for (int j = 0; j < DIAM; j++) win[i][j] <= '0;
    end else begin
      pend <= take;
      if (take) begin
        col_count <= c_next;
        row_count <= r_next;
        pend_px <= pixel_value;
        pend_c <= c;
        pend_r <= r;
      end
      job_valid <= 1'b0;
      if (pend) begin
        for (int i = 0; i < DIAM; i++) begin
          for (int j = 0; j < DIAM - 1; j++) win[i][j] <= win[i][j+1];
          win[i][DIAM-1] <= (i == LINES) ? pend_px : rd[PIX_W*i +: PIX_W];
        end
        job_valid <= (pend_r >= 12'(LINES)) && (pend_c >= CW'(LINES));
        tag_row <= POS_W'(pend_r - 12'(HALF));
        tag_col <= POS_W'(pend_c - CW'(HALF));
        tag_last <= (pend_r == h_lim - 12'd1) && (pend_c == w_lim - CW'(1));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DIAM; i++)
      for (int j = 0; j < DIAM; j++) job.win[PIX_W*(i*DIAM+j) +: PIX_W] = win[i][j];
    job.tag.centre = win[HALF][HALF];
    job.tag.row = tag_row;
    job.tag.col = tag_col;
    job.tag.last = tag_last;
  end
endmodule
`default_nettype wire

### hdl/bf5_queue.sv
// ----------------------------------------------------------------------------
// bf5_queue
// small fifo between window front end and filter back end
// ----------------------------------------------------------------------------
`default_nettype none
module bf5_queue import bf5_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  bf5_job_t      din,
  input  wire logic     pop,
  output logic          not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output bf5_job_t      dout
);
  localparam int PW = $clog2(DEPTH);
  bf5_job_t mem [DEPTH];
  logic [PW-1:0] wp, rp;

  assign not_empty = count != '0;
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      if (pop) rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end
endmodule
`default_nettype wire

### hdl/bf5_back.sv
// ----------------------------------------------------------------------------
// bf5_back
// per-tap weighting (one tap at a time) and restoring divider, one job at a time
// ----------------------------------------------------------------------------
`default_nettype none
module bf5_back import bf5_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_valid,
  input  bf5_job_t                job,
  output logic                    job_take,
  output logic                    idle,
  input  wire logic               tbl_we,
  input  wire logic [7:0]         tbl_idx,
  input  wire logic [15:0]        tbl_val,
  input  wire logic [16*6-1:0]    spatial,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [PIX_W-1:0]        filtered_value,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    frame_last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [15:0] tbl_mem [RANGE_ENTRIES];
  logic [RANGE_ENTRIES-1:0] tbl_ok;
  logic [2:0] state;
  bf5_job_t cur;
  logic [4:0] tap;
  logic [4:0] tap_lat;
  logic [PIX_W-1:0] v, v_lat;
  logic [7:0] diff;
  logic [15:0] rw_raw;
  logic rw_ok;
  logic [15:0] sw, sw_lat;
  logic [31:0] prod;
  logic [15:0] wt;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [5:0] bit_i;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0] rem;
  logic [DEN_W:0] rem_sh;
  logic [2:0] cls [DIAM*DIAM];

  always_comb begin
    for (int k = 0; k < DIAM*DIAM; k++) cls[k] = dist_class(k / DIAM - HALF, k % DIAM - HALF);
    v = cur.win[PIX_W*tap +: PIX_W];
    diff = (v > cur.tag.centre) ? v - cur.tag.centre : cur.tag.centre - v;
    sw = spatial[16*cls[tap] +: 16];
    rem_sh = {rem[DEN_W-1:0], quo[NUM_W-1]};
  end

  assign wt = prod[31:16];
  assign job_take = (state == S_IDLE) && job_valid;
  assign idle = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_idx] <= tbl_val;
    rw_raw <= tbl_mem[diff];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      tbl_ok <= '0;
    end else begin
      if (tbl_we) tbl_ok[tbl_idx] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            tap <= '0;
            num <= '0;
            den <= '0;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          rw_ok <= tbl_ok[diff];
          sw_lat <= sw;
          v_lat <= v;
          tap_lat <= tap;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= sw_lat * (rw_ok ? rw_raw : 16'd0);
          state <= S_ACC;
        end
        S_ACC: begin
          num <= num + NUM_W'(wt * v_lat);
          den <= den + DEN_W'(wt);
          if (tap_lat == 5'(DIAM*DIAM-1)) begin
            state <= S_DIV;
          end else begin
            tap <= tap + 5'd1;
            state <= S_LOOK;
          end
        end
        S_DIV: begin
          if (bit_i == '0 && den == '0) begin
            filtered_value <= cur.tag.centre;
            state <= S_OUT;
          end else if (bit_i == '0) begin
            quo <= num;
            rem <= '0;
            bit_i <= 6'd1;
          end else begin
            if (rem_sh >= {1'b0, den}) begin
              rem <= rem_sh - {1'b0, den};
              quo <= {quo[NUM_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[NUM_W-2:0], 1'b0};
            end
            if (bit_i == 6'(NUM_W)) begin
              bit_i <= '0;
              state <= S_OUT;
              filtered_value <= (rem_sh >= {1'b0, den}) ? {quo[PIX_W-2:0], 1'b1}
                                                        : {quo[PIX_W-2:0], 1'b0};
            end else begin
              bit_i <= bit_i + 6'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_row <= cur.tag.row;
            out_col <= cur.tag.col;
            frame_last <= cur.tag.last;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && !job_valid) bit_i <= '0;
    end
  end
endmodule
`default_nettype wire

### hdl/bf5_checker.sv
// ----------------------------------------------------------------------------
// bf5_checker
// port-level checks of the filter
// ----------------------------------------------------------------------------
`default_nettype none
module bf5_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  filtered_value,
  input wire logic [10:0] out_row,
  input wire logic [10:0] out_col
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_value))
    else $error("stalled result changed");
  a_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row >= 11'd2 && out_col >= 11'd2)
    else $error("border position emitted");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("results closer than the back end allows");
endmodule

bind bilateral_filter_5x5 bf5_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .filtered_value, .out_row, .out_col
);
`default_nettype wire
